@@ src/walc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// walc_pkg: shared types and constants
// Widths, register map, reset values and the zone code used by every
// module of the windowed average level classifier.
// ----------------------------------------------------------------------------
package walc_pkg;

    localparam int SAMPLE_W  = 10;
    localparam int LIMIT_W   = 10;
    localparam int ZONE_W    = 2;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register word index, taken from paddr above the byte offset.
    localparam logic [0:0] REG_LOW_LIMIT  = 1'b0;
    localparam logic [0:0] REG_HIGH_LIMIT = 1'b1;

    localparam logic [LIMIT_W-1:0] LOW_LIMIT_RST  = 10'd60;
    localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST = 10'd80;

    typedef enum logic [ZONE_W-1:0] {
        ZONE_NONE     = 2'd0,
        ZONE_QUIET    = 2'd1,
        ZONE_MODERATE = 2'd2,
        ZONE_LOUD     = 2'd3
    } t_zone;

    typedef struct packed {
        logic [LIMIT_W-1:0] low;
        logic [LIMIT_W-1:0] high;
    } t_limits;

endpackage

@@ src/walc_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// walc_window: sample window and running total
// Shift line of the last WINDOW samples with a running sum kept in step.
// ----------------------------------------------------------------------------
module walc_window #(
    parameter int WINDOW  = 10,
    parameter int TOTAL_W = 14
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic [walc_pkg::SAMPLE_W-1:0] i_sample,
    output logic [TOTAL_W-1:0]           o_total
);

    logic [walc_pkg::SAMPLE_W-1:0] r_taps [WINDOW];
    logic [TOTAL_W-1:0]            r_total;
    logic [TOTAL_W-1:0]            n_total;

    // The result always fits, so modular arithmetic in TOTAL_W bits is exact.
    assign n_total = r_total - TOTAL_W'(r_taps[WINDOW-1]) + TOTAL_W'(i_sample);
    assign o_total = r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            for (int i = 0; i < WINDOW; i++) begin
                r_taps[i] <= '0;
            end
        end else if (i_load) begin
            r_total  <= n_total;
            r_taps[0] <= i_sample;
            for (int i = 1; i < WINDOW; i++) begin
                r_taps[i] <= r_taps[i-1];
            end
        end
    end

endmodule

@@ src/walc_mean.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// walc_mean: window mean
// Divides the window total by WINDOW with one reciprocal multiply.
// ----------------------------------------------------------------------------
module walc_mean #(
    parameter int WINDOW  = 10,
    parameter int TOTAL_W = 14
) (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  logic [TOTAL_W-1:0]           i_total,
    output logic [walc_pkg::SAMPLE_W-1:0] o_mean
);

    // A rounded-up reciprocal with this many fraction bits is exact for
    // every total below 2**TOTAL_W.
    localparam int     SHIFT   = TOTAL_W + $clog2(WINDOW);
    localparam longint RECIP   = ((longint'(1) << SHIFT) + WINDOW - 1) / WINDOW;
    localparam int     RECIP_W = $clog2(RECIP + 1);
    localparam int     PROD_W  = TOTAL_W + RECIP_W;

    logic [PROD_W-1:0]             n_prod;
    logic [walc_pkg::SAMPLE_W-1:0] r_mean;

    assign n_prod = PROD_W'(i_total) * PROD_W'(RECIP);
    assign o_mean = r_mean;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mean <= n_prod[SHIFT +: walc_pkg::SAMPLE_W];
        end
    end

endmodule

@@ src/walc_zone.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// walc_zone: level classifier and result register
// Compares the mean with the limits, keeps the lit zone and holds the result.
// ----------------------------------------------------------------------------
module walc_zone (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [walc_pkg::SAMPLE_W-1:0] i_mean,
    input  walc_pkg::t_limits             i_limits,
    output logic [walc_pkg::SAMPLE_W-1:0] o_average,
    output walc_pkg::t_zone               o_zone,
    output logic                          o_alarm
);

    walc_pkg::t_zone               r_zone;
    walc_pkg::t_zone               n_zone;
    logic                          n_alarm;
    logic                          r_alarm;
    logic [walc_pkg::SAMPLE_W-1:0] r_average;

    // Tests are ordered; a mean on a limit keeps the zone that is lit.
    always_comb begin
        n_zone  = r_zone;
        n_alarm = 1'b0;
        if (i_mean < i_limits.low) begin
            n_zone = walc_pkg::ZONE_QUIET;
        end else if (i_mean > i_limits.low && i_mean < i_limits.high) begin
            n_zone = walc_pkg::ZONE_MODERATE;
        end else if (i_mean > i_limits.high) begin
            n_zone  = walc_pkg::ZONE_LOUD;
            n_alarm = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= walc_pkg::ZONE_NONE;
        end else if (i_load) begin
            r_zone <= n_zone;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_average <= i_mean;
            r_alarm   <= n_alarm;
        end
    end

    assign o_average = r_average;
    assign o_zone    = r_zone;
    assign o_alarm   = r_alarm;

endmodule

@@ src/windowed_average_level_classifier_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_average_level_classifier_core: moving average level classifier
// Averages the last WINDOW sensor samples and sorts the mean into zones.
// ----------------------------------------------------------------------------
// Each accepted word carries one 10-bit sensor sample. The block keeps the
// last WINDOW samples (all zero after reset, so early means count the empty
// slots as zeros), updates a running total, takes the truncated mean and
// classifies it against two limits: below low_limit is quiet, strictly
// between the limits is moderate, above high_limit is loud and raises the
// alarm bit. A mean exactly on a limit leaves the lit zone unchanged.
// The block takes one word every clock cycle; the path is three register
// stages (window total, reciprocal multiply for the mean, classifier and
// result register), each of which takes a new word whenever it is empty
// or its word moves on to the stage after it, so a stalled output only
// holds the block once all stages are full.
// The user writes the limits at APB-style byte addresses 0x0 (low_limit,
// reset 60) and 0x4 (high_limit, reset 80) only while the block is idle,
// which the block does not enforce; reads return the register values.
// ----------------------------------------------------------------------------
module windowed_average_level_classifier_core #(
    parameter int WINDOW = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // Input words. tdata: [9:0] sample, [15:10] ignored.
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [walc_pkg::S_TDATA_W-1:0]  i_s_tdata,

    // Result words. tdata: [9:0] average, [11:10] zone, [12] alarm,
    // [15:13] zero.
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [walc_pkg::M_TDATA_W-1:0]  o_m_tdata,

    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [walc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [walc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [walc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int TOTAL_W = $clog2(WINDOW * (2 ** walc_pkg::SAMPLE_W - 1) + 1);

    // Stage valid flags: window total, mean, result.
    logic r_v1;
    logic r_v2;
    logic r_vo;

    logic out_free;
    logic s2_free;
    logic s1_free;
    logic en1;
    logic en2;
    logic en3;

    logic [TOTAL_W-1:0]                 total;
    logic [walc_pkg::SAMPLE_W-1:0]      mean;
    logic [walc_pkg::SAMPLE_W-1:0]      average;
    walc_pkg::t_zone                    zone;
    logic                               alarm;

    logic [walc_pkg::LIMIT_W-1:0]       r_low_limit;
    logic [walc_pkg::LIMIT_W-1:0]       r_high_limit;
    walc_pkg::t_limits                  limits;
    logic                               cfg_write;
    logic [0:0]                         reg_index;

    // A stage may take a new word when it is empty or its word moves on.
    assign out_free   = !r_vo || i_m_tready;
    assign s2_free    = !r_v2 || out_free;
    assign s1_free    = !r_v1 || s2_free;
    assign en1        = i_s_tvalid && s1_free;
    assign en2        = r_v1 && s2_free;
    assign en3        = r_v2 && out_free;
    assign o_s_tready = s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (s1_free) begin
                r_v1 <= i_s_tvalid;
            end
            if (s2_free) begin
                r_v2 <= r_v1;
            end
            if (out_free) begin
                r_vo <= r_v2;
            end
        end
    end

    walc_window #(
        .WINDOW  (WINDOW),
        .TOTAL_W (TOTAL_W)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (en1),
        .i_sample (i_s_tdata[walc_pkg::SAMPLE_W-1:0]),
        .o_total  (total)
    );

    walc_mean #(
        .WINDOW  (WINDOW),
        .TOTAL_W (TOTAL_W)
    ) u_mean (
        .i_clk   (i_clk),
        .i_load  (en2),
        .i_total (total),
        .o_mean  (mean)
    );

    walc_zone u_zone (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (en3),
        .i_mean    (mean),
        .i_limits  (limits),
        .o_average (average),
        .o_zone    (zone),
        .o_alarm   (alarm)
    );

    assign o_m_tvalid = r_vo;
    assign o_m_tdata  = {3'b000, alarm, zone, average};

    // Configuration registers. The word index sits above the byte offset.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[2:2];
    assign limits    = '{low: r_low_limit, high: r_high_limit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_limit  <= walc_pkg::LOW_LIMIT_RST;
            r_high_limit <= walc_pkg::HIGH_LIMIT_RST;
        end else if (cfg_write) begin
            case (reg_index)
                walc_pkg::REG_LOW_LIMIT: begin
                    r_low_limit <= pwdata[walc_pkg::LIMIT_W-1:0];
                end
                walc_pkg::REG_HIGH_LIMIT: begin
                    r_high_limit <= pwdata[walc_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            walc_pkg::REG_LOW_LIMIT: begin
                prdata = walc_pkg::APB_DATA_W'(r_low_limit);
            end
            walc_pkg::REG_HIGH_LIMIT: begin
                prdata = walc_pkg::APB_DATA_W'(r_high_limit);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for windowed_average_level_classifier_core
// Streams sensor samples into the block and checks every result word
// (average, zone, alarm) against a cycle-free model of the moving window,
// across several limit settings with random idling and a long output stall.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WINDOW       = 10;
    localparam int LATENCY      = 3;
    localparam int STALL_CYCLES = 150;
    localparam int LIMIT_CYCLES = 200000;

    typedef struct {
        logic [9:0]      average;
        walc_pkg::t_zone zone;
        logic            alarm;
    } t_level_result;

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic [walc_pkg::S_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                            i_m_tready = 1'b0;
    logic                            psel       = 1'b0;
    logic                            penable    = 1'b0;
    logic                            pwrite     = 1'b0;
    logic [walc_pkg::APB_ADDR_W-1:0] paddr      = '0;
    logic [walc_pkg::APB_DATA_W-1:0] pwdata     = '0;
    logic                            o_s_tready;
    logic                            o_m_tvalid;
    logic [walc_pkg::M_TDATA_W-1:0]  o_m_tdata;
    logic [walc_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    // Model state of the window and the limits it is classified against.
    logic [9:0]                   win_samples [WINDOW] = '{default: '0};
    int                           win_slot  = 0;
    logic [15:0]                  win_total = '0;
    walc_pkg::t_zone              lit       = walc_pkg::ZONE_NONE;
    logic [walc_pkg::LIMIT_W-1:0] low_lim   = walc_pkg::LOW_LIMIT_RST;
    logic [walc_pkg::LIMIT_W-1:0] high_lim  = walc_pkg::HIGH_LIMIT_RST;

    t_level_result expected_levels [$];

    int  errors         = 0;
    int  cycle_count    = 0;
    int  words_sent     = 0;
    int  results_seen   = 0;
    int  limit_settings = 0;
    int  held_on_limit  = 0;
    int  zone_hits [4]  = '{default: 0};
    bit  steady         = 1'b0;
    int  stall_requests = 0;

    windowed_average_level_classifier_core #(
        .WINDOW(WINDOW)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // [9:0] sample, [15:10] padding
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // [9:0] average, [11:10] zone, [12] alarm
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #6 i_clk = ~i_clk;

    // Run guard: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: run exceeded %0d cycles", $time, LIMIT_CYCLES);
            $display("status: fail");
            $finish;
        end
    end

    // Puts one sample into the window and classifies the new mean. A mean
    // that passes none of the ordered tests keeps the previous zone.
    function automatic t_level_result average_and_classify(input logic [9:0] sample);
        t_level_result r;
        logic [15:0]   mean;
        win_total = win_total - win_samples[win_slot] + sample;
        win_samples[win_slot] = sample;
        win_slot = (win_slot == WINDOW - 1) ? 0 : win_slot + 1;
        mean = win_total / WINDOW;
        r.alarm = 1'b0;
        if (mean < low_lim) begin
            lit = walc_pkg::ZONE_QUIET;
        end else if (mean > low_lim && mean < high_lim) begin
            lit = walc_pkg::ZONE_MODERATE;
        end else if (mean > high_lim) begin
            lit = walc_pkg::ZONE_LOUD;
            r.alarm = 1'b1;
        end else begin
            held_on_limit++;
        end
        zone_hits[lit]++;
        r.average = mean[9:0];
        r.zone    = lit;
        return r;
    endfunction

    // Receiver: random ready, ready held high when steady, and a long
    // hold-off counted here whenever a test asks for one.
    always @(posedge i_clk) begin
        static int stall_served = 0;
        static int stall_left   = 0;
        if (stall_requests != stall_served) begin
            stall_served = stall_requests;
            stall_left   = STALL_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if (steady) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= 19);
        end
    end

    // Result checker: every accepted word is matched against the oldest
    // prediction, field by field.
    always @(posedge i_clk) begin
        t_level_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (expected_levels.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, o_m_tdata);
            end else begin
                want = expected_levels.pop_front();
                if (o_m_tdata[9:0] !== want.average) begin
                    errors++;
                    $display("%0t: average expected %0d actual %0d",
                             $time, want.average, o_m_tdata[9:0]);
                end
                if (o_m_tdata[11:10] !== want.zone) begin
                    errors++;
                    $display("%0t: zone expected %0d actual %0d",
                             $time, want.zone, o_m_tdata[11:10]);
                end
                if (o_m_tdata[12] !== want.alarm) begin
                    errors++;
                    $display("%0t: alarm expected %0b actual %0b",
                             $time, want.alarm, o_m_tdata[12]);
                end
            end
        end
    end

    // Offers one word, with a random idle gap in front unless steady.
    // Valid stays high across back-to-back words.
    task automatic send_word(input logic [walc_pkg::S_TDATA_W-1:0] word);
        int gap;
        gap = 0;
        if (!steady) begin
            while ($urandom_range(99) < 19 && gap < 30) gap++;
        end
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= word;
        do @(posedge i_clk); while (!o_s_tready);
        words_sent++;
        expected_levels.push_back(average_and_classify(word[9:0]));
    endtask

    // Stops offering and waits until every result is back and the
    // pipeline has had time to empty.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (expected_levels.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [0:0] index,
                             input logic [walc_pkg::APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == walc_pkg::REG_LOW_LIMIT) low_lim = value[9:0];
        else high_lim = value[9:0];
        @(posedge i_clk);
    endtask

    // Writes both limits with junk above bit 9, which the block must ignore.
    task automatic write_limits(input int lo, input int hi);
        apb_write(walc_pkg::REG_LOW_LIMIT, {22'($urandom()), 10'(lo)});
        apb_write(walc_pkg::REG_HIGH_LIMIT, {22'($urandom()), 10'(hi)});
        limit_settings++;
    endtask

    // A sample near a level, now and then a wild one or one with padding set.
    function automatic logic [walc_pkg::S_TDATA_W-1:0] level_word(input int center,
                                                                   input int spread);
        int                             v;
        logic [walc_pkg::S_TDATA_W-1:0] w;
        v = center + int'($urandom_range(2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        w = {6'd0, 10'(v)};
        if ($urandom_range(99) < 5) w[9:0] = 10'($urandom_range(1023));
        if ($urandom_range(99) < 3) w[15:10] = 6'($urandom_range(63));
        return w;
    endfunction

    // Reset limits: a mean sitting on either limit before any zone is lit,
    // the first loud alarm, quiet, moderate, full-scale and padded samples.
    task automatic test_window_fill();
        send_word(16'd600);     // mean 60, on the low limit, nothing lit
        send_word(16'd200);     // mean 80, on the high limit
        send_word(16'd0);
        send_word(16'd1023);    // loud
        send_word(16'hFC00);    // padding only, sample zero
        repeat (5) send_word(16'd0);
        repeat (4) send_word(16'd0);  // old samples age out, mean falls to quiet
        send_word(16'd700);     // moderate
        send_word(16'hFFFF);    // full scale with padding set
    endtask

    // Low limit above high limit: everything under the low limit is quiet,
    // even means above the high limit, and no alarm.
    task automatic test_crossed_limits();
        settle();
        write_limits(900, 100);
        repeat (3) send_word(16'd1023);
    endtask

    // Both limits at full scale: quiet until the window is full of 1023,
    // then the mean sits on both limits and the zone holds.
    task automatic test_full_scale_limits();
        settle();
        write_limits(1023, 1023);
        repeat (10) send_word(16'd1023);
    endtask

    // Random phases, each with its own limits; bursts of samples hover
    // around a limit, an extreme or a random level so means cross and land
    // exactly on the limits.
    task automatic test_random_levels();
        int lo, hi, center, spread, burst, sent, pick;
        for (int phase = 0; phase < 7; phase++) begin
            settle();
            case (phase % 4)
                0: begin
                    lo = $urandom_range(1023);
                    hi = $urandom_range(1023);
                end
                1: begin
                    center = $urandom_range(1023);
                    spread = $urandom_range(40);
                    lo = (center - spread < 0) ? 0 : center - spread;
                    hi = (center + spread > 1023) ? 1023 : center + spread;
                end
                2: begin
                    lo = $urandom_range(1) ? 1023 : 0;
                    hi = $urandom_range(1) ? 1023 : 0;
                end
                default: begin
                    hi = $urandom_range(600);
                    lo = hi + $urandom_range(1, 423);
                end
            endcase
            write_limits(lo, hi);
            steady = (phase == 3);
            sent = 0;
            while (sent < 165) begin
                burst = $urandom_range(10, 60);
                pick  = $urandom_range(3);
                case (pick)
                    0: center = lo;
                    1: center = hi;
                    2: center = $urandom_range(1023);
                    default: center = $urandom_range(1) ? 1023 : 0;
                endcase
                case ($urandom_range(2))
                    0: spread = 0;
                    1: spread = $urandom_range(8);
                    default: spread = $urandom_range(200);
                endcase
                for (int k = 0; k < burst && sent < 165; k++) begin
                    send_word(level_word(center, spread));
                    sent++;
                end
            end
        end
        steady = 1'b0;
    endtask

    // The receiver holds off while words keep coming, so the pipeline fills
    // and the input must stall until the hold-off ends.
    task automatic test_output_stall();
        settle();
        write_limits(300, 700);
        stall_requests++;
        repeat (40) send_word(level_word($urandom_range(1023), 300));
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_window_fill();
        test_crossed_limits();
        test_full_scale_limits();
        test_random_levels();
        test_output_stall();
        settle();

        $display("covered %0d sample words, %0d results: quiet %0d, moderate %0d, loud %0d",
                 words_sent, results_seen, zone_hits[walc_pkg::ZONE_QUIET],
                 zone_hits[walc_pkg::ZONE_MODERATE], zone_hits[walc_pkg::ZONE_LOUD]);
        $display("%0d held on a limit, %0d limit settings, one %0d-cycle output stall",
                 held_on_limit, limit_settings, STALL_CYCLES);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
